@@ rtl/fastpath_input_pdu_parser_macros.svh @@
// Assertion macros used by the fast-path input parser checker.
`ifndef FASTPATH_INPUT_PDU_PARSER_MACROS_SVH
`define FASTPATH_INPUT_PDU_PARSER_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define FPIP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("fpip assertion failed");

// Check that a consequent holds in the cycle after an antecedent.
`define FPIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpip assertion failed");

`endif

@@ rtl/fpip_pkg.sv @@
// Types, codes and helpers of the fast-path input PDU parser.
`default_nettype none
package fpip_pkg;

  typedef enum logic [2:0] {
    PH_HDR     = 3'd0,
    PH_LEN1    = 3'd1,
    PH_LEN2    = 3'd2,
    PH_EVHDR   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_IDLE    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MORE   = 2'd1,
    ST_BADLEN = 2'd2,
    ST_UNSUP  = 2'd3
  } status_e;

  localparam logic [2:0]  PayUnknown = 3'd7;
  localparam logic [15:0] BytesMax   = 16'hffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  event_count;
    logic [2:0]  first_event_code;
    logic [15:0] first_event_flags;
    logic [15:0] first_pointer_x;
    logic [15:0] first_pointer_y;
    logic [7:0]  first_key_code;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_req_t;

  // Payload bytes that follow an event header; unknown codes map to PayUnknown.
  function automatic logic [2:0] payload_size(input logic [2:0] code);
    logic [2:0] n;
    case (code)
      3'd0:    n = 3'd1;
      3'd3:    n = 3'd0;
      3'd4:    n = 3'd2;
      3'd1:    n = 3'd6;
      3'd5:    n = 3'd6;
      default: n = PayUnknown;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ rtl/fpip_if.sv @@
// Request channel interfaces of the fast-path input PDU parser.
`default_nettype none
interface fpip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface fpip_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  event_count;
  logic [2:0]  first_event_code;
  logic [15:0] first_event_flags;
  logic [15:0] first_pointer_x;
  logic [15:0] first_pointer_y;
  logic [7:0]  first_key_code;

  modport source (output valid, output status, output event_count, output first_event_code,
                  output first_event_flags, output first_pointer_x, output first_pointer_y,
                  output first_key_code, input ready);
  modport sink (input valid, input status, input event_count, input first_event_code,
                input first_event_flags, input first_pointer_x, input first_pointer_y,
                input first_key_code, output ready);
endinterface
`default_nettype wire

@@ rtl/fpip_in_stage.sv @@
// Input register of the parser: holds one byte request until the core takes it.
`default_nettype none
module fpip_in_stage (
  input  wire              clk_i,
  input  wire              rst_ni,
  fpip_in_if.sink          pdu_i,
  input  wire              take_i,
  output logic             item_valid_o,
  output fpip_pkg::in_t    item_o
);
  import fpip_pkg::*;

  logic valid_q, valid_d;
  in_t  item_q, item_d;
  logic accept;

  assign pdu_i.ready = !valid_q || take_i;
  assign accept      = pdu_i.valid && pdu_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d = 1'b1;
      item_d  = '{data_byte: pdu_i.data_byte, end_of_buffer: pdu_i.end_of_buffer};
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
endmodule
`default_nettype wire

@@ rtl/fpip_core.sv @@
// Parser state and the per-byte update that walks header, length and events.
`default_nettype none
module fpip_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 item_valid_i,
  input  fpip_pkg::in_t       item_i,
  input  wire                 out_free_i,
  output logic                take_o,
  output fpip_pkg::res_req_t  res_o
);
  import fpip_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] seen_q, seen_d;
  logic [14:0] decl_q, decl_d;
  logic [3:0]  total_q, total_d;
  logic [3:0]  done_q, done_d;
  logic [2:0]  left_q, left_d;
  logic [2:0]  code_q, code_d;
  status_e     hdr_err_q, hdr_err_d;
  status_e     ev_err_q, ev_err_d;
  logic [55:0] fields_q, fields_d;
  logic [2:0]  first_code_q, first_code_d;

  logic [7:0]  b;
  logic [2:0]  n;
  logic [2:0]  idx;
  logic [2:0]  new_code;
  logic        mouse;
  status_e     st;
  logic        fire;

  assign b    = item_i.data_byte;
  // Stall only a final byte whose result has nowhere to go.
  assign fire   = item_valid_i && (!item_i.end_of_buffer || out_free_i);
  assign take_o = fire;

  always_comb begin
    phase_d      = phase_q;
    seen_d       = (seen_q == BytesMax) ? seen_q : seen_q + 16'd1;
    decl_d       = decl_q;
    total_d      = total_q;
    done_d       = done_q;
    left_d       = left_q;
    code_d       = code_q;
    hdr_err_d    = hdr_err_q;
    ev_err_d     = ev_err_q;
    fields_d     = fields_q;
    first_code_d = first_code_q;
    new_code     = b[7:5];
    n            = payload_size(code_q);
    idx          = n - left_q;
    mouse        = (code_q == 3'd1) || (code_q == 3'd5);

    case (phase_q)
      PH_HDR: begin
        total_d = b[5:2];
        if (b[1:0] != 2'b00) begin
          hdr_err_d = ST_UNSUP;
        end else if (b[5:2] == 4'd0) begin
          hdr_err_d = ST_BADLEN;
        end
        phase_d = PH_LEN1;
      end
      PH_LEN1: begin
        if (b[7]) begin
          decl_d  = {b[6:0], 8'h00};
          phase_d = PH_LEN2;
        end else begin
          decl_d = {8'h00, b[6:0]};
          if (b < 8'd2 && hdr_err_q == ST_OK) begin
            hdr_err_d = ST_BADLEN;
          end
          phase_d = PH_EVHDR;
        end
      end
      PH_LEN2: begin
        decl_d = {decl_q[14:8], decl_q[7:0] | b};
        if ({decl_q[14:8], decl_q[7:0] | b} < 15'd3 && hdr_err_q == ST_OK) begin
          hdr_err_d = ST_BADLEN;
        end
        phase_d = PH_EVHDR;
      end
      PH_EVHDR: begin
        n = payload_size(new_code);
        if (done_q >= total_q) begin
          if (ev_err_q == ST_OK) begin
            ev_err_d = ST_BADLEN;
          end
          phase_d = PH_IDLE;
        end else begin
          code_d = new_code;
          if (n == PayUnknown) begin
            if (ev_err_q == ST_OK) begin
              ev_err_d = ST_UNSUP;
            end
            phase_d = PH_IDLE;
          end else begin
            if (done_q == 4'd0) begin
              first_code_d = new_code;
              fields_d     = {51'd0, b[4:0]};
            end
            left_d = n;
            if (n == 3'd0) begin
              done_d = done_q + 4'd1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (done_q == 4'd0) begin
          if (mouse) begin
            case (idx)
              3'd0:    fields_d[15:0]  = {8'h00, b};
              3'd1:    fields_d[15:8]  = fields_q[15:8] | b;
              3'd2:    fields_d[23:16] = fields_q[23:16] | b;
              3'd3:    fields_d[31:24] = fields_q[31:24] | b;
              3'd4:    fields_d[39:32] = fields_q[39:32] | b;
              3'd5:    fields_d[47:40] = fields_q[47:40] | b;
              default: fields_d        = fields_q;
            endcase
          end else if (code_q == 3'd0) begin
            fields_d[55:48] = fields_q[55:48] | b;
          end
        end
        left_d = (left_q != 3'd0) ? left_q - 3'd1 : left_q;
        if (left_d == 3'd0) begin
          done_d  = done_q + 4'd1;
          phase_d = PH_EVHDR;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    // Resolve the status from the updated state.
    if (seen_d < 16'd2) begin
      st = ST_MORE;
    end else if (hdr_err_d != ST_OK) begin
      st = hdr_err_d;
    end else if (phase_d == PH_LEN2) begin
      st = ST_MORE;
    end else if ({1'b0, decl_d} > seen_d) begin
      st = ST_MORE;
    end else if ({1'b0, decl_d} != seen_d) begin
      st = ST_BADLEN;
    end else if (ev_err_d != ST_OK) begin
      st = ev_err_d;
    end else if (done_d < total_d) begin
      st = (phase_d == PH_PAYLOAD) ? ST_MORE : ST_BADLEN;
    end else begin
      st = ST_OK;
    end

    res_o.valid = fire && item_i.end_of_buffer;
    res_o.res   = '{status: st, event_count: 4'd0, first_event_code: 3'd0,
                    first_event_flags: 16'd0, first_pointer_x: 16'd0,
                    first_pointer_y: 16'd0, first_key_code: 8'd0};
    if (st == ST_OK) begin
      res_o.res.event_count       = total_d;
      res_o.res.first_event_code  = first_code_d;
      res_o.res.first_event_flags = fields_d[15:0];
      res_o.res.first_pointer_x   = fields_d[31:16];
      res_o.res.first_pointer_y   = fields_d[47:32];
      res_o.res.first_key_code    = fields_d[55:48];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR;
      seen_q       <= 16'd0;
      decl_q       <= 15'd0;
      total_q      <= 4'd0;
      done_q       <= 4'd0;
      left_q       <= 3'd0;
      code_q       <= 3'd0;
      hdr_err_q    <= ST_OK;
      ev_err_q     <= ST_OK;
      fields_q     <= 56'd0;
      first_code_q <= 3'd0;
    end else if (fire) begin
      if (item_i.end_of_buffer) begin
        // Start over for the next buffer.
        phase_q      <= PH_HDR;
        seen_q       <= 16'd0;
        decl_q       <= 15'd0;
        total_q      <= 4'd0;
        done_q       <= 4'd0;
        left_q       <= 3'd0;
        code_q       <= 3'd0;
        hdr_err_q    <= ST_OK;
        ev_err_q     <= ST_OK;
        fields_q     <= 56'd0;
        first_code_q <= 3'd0;
      end else begin
        phase_q      <= phase_d;
        seen_q       <= seen_d;
        decl_q       <= decl_d;
        total_q      <= total_d;
        done_q       <= done_d;
        left_q       <= left_d;
        code_q       <= code_d;
        hdr_err_q    <= hdr_err_d;
        ev_err_q     <= ev_err_d;
        fields_q     <= fields_d;
        first_code_q <= first_code_d;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/fpip_out_stage.sv @@
// Result register of the parser: holds one result request until the sink takes it.
`default_nettype none
module fpip_out_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  fpip_pkg::res_req_t  res_i,
  output logic                free_o,
  fpip_out_if.source          res_o
);
  import fpip_pkg::*;

  logic valid_q, valid_d;
  res_t res_q, res_d;

  assign free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
      res_d   = res_i.res;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o.valid             = valid_q;
  assign res_o.status            = res_q.status;
  assign res_o.event_count       = res_q.event_count;
  assign res_o.first_event_code  = res_q.first_event_code;
  assign res_o.first_event_flags = res_q.first_event_flags;
  assign res_o.first_pointer_x   = res_q.first_pointer_x;
  assign res_o.first_pointer_y   = res_q.first_pointer_y;
  assign res_o.first_key_code    = res_q.first_key_code;
endmodule
`default_nettype wire

@@ rtl/fastpath_input_pdu_parser.sv @@
// Top level of the fast-path input PDU parser.
//
//   channel | dir | payload                                  | handshake
//   pdu_i   | in  | data_byte, end_of_buffer                 | valid/ready
//   res_o   | out | status, event_count, first event fields  | valid/ready
//
// One byte is taken per cycle while no final byte stalls; a byte is processed
// from the input register once accepted, and its result (final byte only)
// shows on res_o the cycle after. The per-byte update is a single pass from the
// input register to the state and result registers. Reset clears the parser
// to expect a header byte. A final byte waits in the input register only while
// an untaken result holds the output register; other bytes never stall.
`default_nettype none
module fastpath_input_pdu_parser (
  input  wire         clk_i,
  input  wire         rst_ni,
  fpip_in_if.sink     pdu_i,
  fpip_out_if.source  res_o
);
  import fpip_pkg::*;

  logic     item_valid;
  in_t      item;
  logic     take;
  logic     out_free;
  res_req_t res_req;

  fpip_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pdu_i        (pdu_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  fpip_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_free_i   (out_free),
    .take_o       (take),
    .res_o        (res_req)
  );

  fpip_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res_req),
    .free_o (out_free),
    .res_o  (res_o)
  );
endmodule
`default_nettype wire

@@ rtl/fpip_checker.sv @@
// Port checker of the fast-path input PDU parser and its bind.
`default_nettype none
`include "fastpath_input_pdu_parser_macros.svh"
module fpip_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [1:0]  status_i,
  input wire [3:0]  event_count_i,
  input wire [2:0]  first_event_code_i,
  input wire [15:0] first_event_flags_i,
  input wire [15:0] first_pointer_x_i,
  input wire [15:0] first_pointer_y_i,
  input wire [7:0]  first_key_code_i
);
  import fpip_pkg::*;

  logic fail;
  logic zero_fields;

  assign fail        = status_i != ST_OK;
  assign zero_fields = (event_count_i == 4'd0) && (first_event_code_i == 3'd0) &&
                       (first_event_flags_i == 16'd0) && (first_pointer_x_i == 16'd0) &&
                       (first_pointer_y_i == 16'd0) && (first_key_code_i == 8'd0);

  `FPIP_ASSERT(a_fail_zero, !(out_valid_i && fail) || zero_fields)
  `FPIP_ASSERT(a_ok_count, !(out_valid_i && !fail) || (event_count_i != 4'd0))
  `FPIP_ASSERT_NEXT(a_hold_valid, out_valid_i && !out_ready_i, out_valid_i)
  `FPIP_ASSERT_NEXT(a_hold_status, out_valid_i && !out_ready_i, $stable(status_i))
endmodule

bind fastpath_input_pdu_parser fpip_checker u_fpip_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (res_o.valid),
  .out_ready_i         (res_o.ready),
  .status_i            (res_o.status),
  .event_count_i       (res_o.event_count),
  .first_event_code_i  (res_o.first_event_code),
  .first_event_flags_i (res_o.first_event_flags),
  .first_pointer_x_i   (res_o.first_pointer_x),
  .first_pointer_y_i   (res_o.first_pointer_y),
  .first_key_code_i    (res_o.first_key_code)
);
`default_nettype wire

@@ bench/fastpath_input_pdu_parser_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the fast-path input PDU parser: framed byte traffic against a byte model.
module fastpath_input_pdu_parser_tb;
  import fpip_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned IdlePct    = 11;
  localparam int unsigned RandBytes  = 1200;

  localparam logic [2:0] CodeScan    = 3'd0;
  localparam logic [2:0] CodeMouse   = 3'd1;
  localparam logic [2:0] CodeRsv2    = 3'd2;
  localparam logic [2:0] CodeSync    = 3'd3;
  localparam logic [2:0] CodeUnicode = 3'd4;
  localparam logic [2:0] CodeMouseX  = 3'd5;
  localparam logic [2:0] CodeRsv6    = 3'd6;
  localparam logic [2:0] CodeRsv7    = 3'd7;
  localparam logic [7:0] LenLong     = 8'h80;

  logic clk_i;
  logic rst_ni;

  fpip_in_if  pdu_if();
  fpip_out_if res_if();

  fastpath_input_pdu_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pdu_i  (pdu_if),
    .res_o  (res_if)
  );

  // Parse model state
  phase_e      parse_ph;
  logic [15:0] seen_cnt;
  logic [14:0] decl_len;
  logic [3:0]  ev_total;
  logic [3:0]  ev_done;
  logic [2:0]  pay_left;
  logic [2:0]  cur_code;
  logic [2:0]  first_code;
  status_e     hdr_err;
  status_e     ev_err;
  logic [15:0] f_flags;
  logic [15:0] f_x;
  logic [15:0] f_y;
  logic [7:0]  f_key;

  res_t        verdict_q[$];
  logic [7:0]  frame[$];
  int unsigned hdr_pos[$];
  bit          calm;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("fastpath_input_pdu_parser_tb: errors");
      $finish;
    end
  end

  function automatic logic [2:0] body_len(input logic [2:0] code);
    case (code)
      CodeScan:    return 3'd1;
      CodeSync:    return 3'd0;
      CodeUnicode: return 3'd2;
      CodeMouse:   return 3'd6;
      CodeMouseX:  return 3'd6;
      default:     return PayUnknown;
    endcase
  endfunction

  function automatic logic [2:0] good_code(input int k);
    case (k)
      0:       return CodeScan;
      1:       return CodeMouse;
      2:       return CodeSync;
      3:       return CodeUnicode;
      default: return CodeMouseX;
    endcase
  endfunction

  function automatic logic [2:0] bad_code(input int k);
    case (k)
      0:       return CodeRsv2;
      1:       return CodeRsv6;
      default: return CodeRsv7;
    endcase
  endfunction

  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] fill_byte(input int fill);
    return (fill < 0) ? rnd_byte() : fill[7:0];
  endfunction

  task clear_parse();
    parse_ph   = PH_HDR;
    seen_cnt   = '0;
    decl_len   = '0;
    ev_total   = '0;
    ev_done    = '0;
    pay_left   = '0;
    cur_code   = '0;
    first_code = '0;
    hdr_err    = ST_OK;
    ev_err     = ST_OK;
    f_flags    = '0;
    f_x        = '0;
    f_y        = '0;
    f_key      = '0;
  endtask

  // Advance the parse model by one accepted byte; queue the verdict on the last byte.
  task parse_byte(input logic [7:0] b, input logic eob);
    logic [2:0] n;
    logic [2:0] idx;
    status_e    st;
    res_t       r;
    if (seen_cnt != BytesMax) seen_cnt = seen_cnt + 16'd1;
    case (parse_ph)
      PH_HDR: begin
        ev_total = b[5:2];
        if (b[1:0] != 2'b00) hdr_err = ST_UNSUP;
        else if (b[5:2] == 4'd0) hdr_err = ST_BADLEN;
        parse_ph = PH_LEN1;
      end
      PH_LEN1: begin
        if (b[7]) begin
          decl_len = {b[6:0], 8'h00};
          parse_ph = PH_LEN2;
        end else begin
          decl_len = {8'h00, b[6:0]};
          if (b < 8'd2 && hdr_err == ST_OK) hdr_err = ST_BADLEN;
          parse_ph = PH_EVHDR;
        end
      end
      PH_LEN2: begin
        decl_len = {decl_len[14:8], b};
        if (decl_len < 15'd3 && hdr_err == ST_OK) hdr_err = ST_BADLEN;
        parse_ph = PH_EVHDR;
      end
      PH_EVHDR: begin
        if (ev_done >= ev_total) begin
          if (ev_err == ST_OK) ev_err = ST_BADLEN;
          parse_ph = PH_IDLE;
        end else begin
          cur_code = b[7:5];
          n = body_len(cur_code);
          if (n == PayUnknown) begin
            if (ev_err == ST_OK) ev_err = ST_UNSUP;
            parse_ph = PH_IDLE;
          end else begin
            if (ev_done == 4'd0) begin
              first_code = cur_code;
              f_flags = {11'd0, b[4:0]};
              f_x = '0;
              f_y = '0;
              f_key = '0;
            end
            pay_left = n;
            if (n == 3'd0) ev_done = ev_done + 4'd1;
            else parse_ph = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        idx = body_len(cur_code) - pay_left;
        if (ev_done == 4'd0) begin
          if (cur_code == CodeMouse || cur_code == CodeMouseX) begin
            // pointer flags word replaces the header bits, then x and y follow
            case (idx)
              3'd0: f_flags = {8'h00, b};
              3'd1: f_flags[15:8] = f_flags[15:8] | b;
              3'd2: f_x[7:0] = f_x[7:0] | b;
              3'd3: f_x[15:8] = f_x[15:8] | b;
              3'd4: f_y[7:0] = f_y[7:0] | b;
              3'd5: f_y[15:8] = f_y[15:8] | b;
              default: ;
            endcase
          end else if (cur_code == CodeScan) begin
            f_key = f_key | b;
          end
        end
        if (pay_left != 3'd0) pay_left = pay_left - 3'd1;
        if (pay_left == 3'd0) begin
          ev_done = ev_done + 4'd1;
          parse_ph = PH_EVHDR;
        end
      end
      default: ;
    endcase

    if (eob) begin
      if (seen_cnt < 16'd2) st = ST_MORE;
      else if (hdr_err != ST_OK) st = hdr_err;
      else if (parse_ph == PH_LEN2) st = ST_MORE;
      else if ({1'b0, decl_len} > seen_cnt) st = ST_MORE;
      else if ({1'b0, decl_len} != seen_cnt) st = ST_BADLEN;
      else if (ev_err != ST_OK) st = ev_err;
      else if (ev_done < ev_total) st = (parse_ph == PH_PAYLOAD) ? ST_MORE : ST_BADLEN;
      else st = ST_OK;
      r = '0;
      r.status = st;
      if (st == ST_OK) begin
        r.event_count       = ev_total;
        r.first_event_code  = first_code;
        r.first_event_flags = f_flags;
        r.first_pointer_x   = f_x;
        r.first_pointer_y   = f_y;
        r.first_key_code    = f_key;
      end
      verdict_q.push_back(r);
      clear_parse();
    end
  endtask

  // Present one byte, hold it until taken, then fold it into the model.
  task send_byte(input logic [7:0] b, input logic eob);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      pdu_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pdu_if.valid         <= 1'b1;
    pdu_if.data_byte     <= b;
    pdu_if.end_of_buffer <= eob;
    @(posedge clk_i);
    while (!pdu_if.ready) @(posedge clk_i);
    parse_byte(b, eob);
    sent_cnt++;
  endtask

  task send_frame();
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task drain_results();
    pdu_if.valid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // Rewrite the length field so that it matches the frame as it stands.
  task fix_length();
    logic [15:0] total;
    logic [7:0]  lb;
    total = 16'(frame.size());
    if (frame.size() < 2) return;
    lb = frame[1];
    if (lb[7]) begin
      if (frame.size() >= 3) begin
        frame[1] = LenLong | {1'b0, total[14:8]};
        frame[2] = total[7:0];
      end
    end else if (total < 16'd128) begin
      frame[1] = total[7:0];
    end
  endtask

  // Build a well-formed request; code_sel < 0 picks codes at random, fill < 0 random bytes.
  task build_frame(input int nev, input int code_sel, input bit long_form, input int fill);
    logic [2:0] code;
    logic [7:0] hb;
    frame.delete();
    hdr_pos.delete();
    frame.push_back({2'($urandom), 4'(nev), 2'b00});
    frame.push_back(long_form ? LenLong : 8'h00);
    if (long_form) frame.push_back(8'h00);
    for (int i = 0; i < nev; i++) begin
      code = (code_sel < 0) ? good_code($urandom_range(0, 4)) : code_sel[2:0];
      hb = fill_byte(fill);
      hdr_pos.push_back(frame.size());
      frame.push_back({code, hb[4:0]});
      for (int j = 0; j < body_len(code); j++) frame.push_back(fill_byte(fill));
    end
    fix_length();
  endtask

  task break_frame();
    logic [7:0]  hb;
    int unsigned k;
    case ($urandom_range(0, 9))
      0: begin
        hb = frame[0];
        hb[1:0] = 2'($urandom_range(1, 3));
        frame[0] = hb;
      end
      1: begin
        hb = frame[0];
        hb[5:2] = 4'd0;
        frame[0] = hb;
      end
      2: begin
        hb = frame[0];
        hb[5:2] = 4'($urandom);
        frame[0] = hb;
        fix_length();
      end
      3: begin
        k = $urandom_range(1, frame.size() - 1);
        repeat (k) void'(frame.pop_back());
        if ($urandom_range(0, 1)) fix_length();
      end
      4: begin
        repeat ($urandom_range(1, 3)) frame.push_back(rnd_byte());
        if ($urandom_range(0, 1)) fix_length();
      end
      5: begin
        k = hdr_pos[$urandom_range(0, hdr_pos.size() - 1)];
        hb = frame[k];
        hb[7:5] = bad_code($urandom_range(0, 2));
        frame[k] = hb;
      end
      6: frame[1] = frame[1] ^ (8'd1 << $urandom_range(0, 7));
      7: begin
        frame.delete();
        repeat ($urandom_range(1, 24)) frame.push_back(rnd_byte());
      end
      8: begin
        // long length form cut after its first byte
        frame.delete();
        frame.push_back(rnd_byte());
        frame.push_back(LenLong | rnd_byte());
      end
      default: begin
        frame.delete();
        frame.push_back(rnd_byte());
      end
    endcase
  endtask

  task test_short_buffers();
    frame.delete();
    frame.push_back(8'h04);
    send_frame();
    frame.push_back(8'h02);
    send_frame();
    drain_results();
  endtask

  task test_header_checks();
    logic [7:0] hb;
    for (int a = 1; a < 4; a++) begin
      build_frame(1, CodeScan, 0, -1);
      hb = frame[0];
      hb[1:0] = 2'(a);
      frame[0] = hb;
      send_frame();
    end
    build_frame(1, CodeSync, 0, -1);
    hb = frame[0];
    hb[5:2] = 4'd0;
    frame[0] = hb;
    send_frame();
    drain_results();
  endtask

  task test_length_field();
    build_frame(1, CodeSync, 0, -1);
    frame[1] = 8'h00;
    send_frame();
    frame[1] = 8'h01;
    send_frame();
    build_frame(1, CodeSync, 1, -1);
    frame[1] = LenLong;
    frame[2] = 8'h02;
    send_frame();
    frame.delete();
    frame.push_back(8'h04);
    frame.push_back(LenLong | 8'h05);
    send_frame();
    build_frame(1, CodeUnicode, 1, -1);
    frame[1] = 8'hff;
    frame[2] = 8'hff;
    send_frame();
    build_frame(2, -1, 0, -1);
    void'(frame.pop_back());
    send_frame();
    build_frame(2, -1, 0, -1);
    frame.push_back(rnd_byte());
    send_frame();
    drain_results();
  endtask

  task test_event_kinds();
    logic [7:0] hb;
    for (int k = 0; k < 5; k++) begin
      build_frame(1, good_code(k), 0, 8'h00);
      send_frame();
      build_frame(1, good_code(k), 1, 8'hff);
      send_frame();
    end
    build_frame(15, -1, 1, -1);
    send_frame();
    for (int k = 0; k < 3; k++) begin
      build_frame(1, bad_code(k), 0, -1);
      send_frame();
    end
    // count claims one more event than the frame holds
    build_frame(2, -1, 0, -1);
    hb = frame[0];
    hb[5:2] = 4'd3;
    frame[0] = hb;
    send_frame();
    build_frame(1, CodeMouse, 0, -1);
    repeat (2) void'(frame.pop_back());
    fix_length();
    send_frame();
    build_frame(1, CodeScan, 0, -1);
    frame.push_back(rnd_byte());
    fix_length();
    send_frame();
    // unknown second event ahead of a cut payload: the earlier fault wins
    build_frame(2, CodeMouse, 0, -1);
    hb = frame[hdr_pos[1]];
    hb[7:5] = CodeRsv6;
    frame[hdr_pos[1]] = hb;
    void'(frame.pop_back());
    fix_length();
    send_frame();
    drain_results();
  endtask

  task test_random_traffic();
    int nev;
    while (sent_cnt < RandBytes) begin
      calm = (sent_cnt >= 400 && sent_cnt < 700);
      nev = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 3);
      build_frame(nev, -1, $urandom_range(0, 3) == 0, -1);
      if ($urandom_range(0, 99) < 30) break_frame();
      send_frame();
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin : res_sink
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result: status %0d", res_if.status);
      end else begin
        want = verdict_q.pop_front();
        if (res_if.status !== want.status ||
            res_if.event_count !== want.event_count ||
            res_if.first_event_code !== want.first_event_code ||
            res_if.first_event_flags !== want.first_event_flags ||
            res_if.first_pointer_x !== want.first_pointer_x ||
            res_if.first_pointer_y !== want.first_pointer_y ||
            res_if.first_key_code !== want.first_key_code) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch want: st %0d cnt %0d code %0d flags %h x %h y %h key %h",
                     want.status, want.event_count, want.first_event_code,
                     want.first_event_flags, want.first_pointer_x, want.first_pointer_y,
                     want.first_key_code);
            $display("         got:  st %0d cnt %0d code %0d flags %h x %h y %h key %h",
                     res_if.status, res_if.event_count, res_if.first_event_code,
                     res_if.first_event_flags, res_if.first_pointer_x, res_if.first_pointer_y,
                     res_if.first_key_code);
          end
        end
      end
    end
    res_if.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  initial begin
    rst_ni               = 1'b0;
    calm                 = 1'b0;
    pdu_if.valid         = 1'b0;
    pdu_if.data_byte     = 8'h00;
    pdu_if.end_of_buffer = 1'b0;
    res_if.ready         = 1'b0;
    clear_parse();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_buffers();
    test_header_checks();
    test_length_field();
    test_event_kinds();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("fastpath_input_pdu_parser_tb: clean");
    end else begin
      $display("fastpath_input_pdu_parser_tb: errors");
    end
    $finish;
  end

endmodule
